FILE: hdl/cdq_pkg.sv
// cdq_pkg: operation and status codes, field widths and the result record
// shared by the circular deque core, its control unit and its channel interfaces.
// No dependencies.
`default_nettype none

package cdq_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CNT_W  = 11;

   localparam logic [CNT_W-1:0] USABLE_RESET = 11'd1024;

   typedef enum logic [1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_REAR  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_REAR   = 2'd3
   } cdq_kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } cdq_status_type;

   // Store access issued for one item.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } cdq_mem_ctl_type;

   // Bookkeeping outcome of one item, carried alongside the store read.
   typedef struct packed {
      logic                 pop_ok;
      cdq_status_type       status;
      logic [CNT_W-1:0]     occupancy;
   } cdq_result_type;

endpackage

`default_nettype wire

FILE: hdl/cdq_req_if.sv
// cdq_req_if / cdq_rsp_if: valid/ready channels for operation items and
// result items of the circular deque core. Depends on cdq_pkg.
`default_nettype none

interface cdq_req_if import cdq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   cdq_kind_type             kind;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, kind, value, input ready);
   modport sink   (input valid, kind, value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] popped_value;
   cdq_status_type           status;
   logic [CNT_W-1:0]         occupancy;

   modport source (output valid, popped_value, status, occupancy, input ready);
   modport sink   (input valid, popped_value, status, occupancy, output ready);
endinterface

`default_nettype wire

FILE: hdl/circular_deque_core.sv
// circular_deque_core: top level of the ring-buffer double-ended queue.
// Depends on cdq_pkg, cdq_req_if/cdq_rsp_if, cdq_ctrl and cdq_ring_mem.
//
// Usage:
//  - req_ch carries one operation item (kind, value); rsp_ch returns exactly one
//    result item per operation (popped_value, status, occupancy), in order.
//  - csr_we/csr_wdata set the number of ring entries in use (0 acts as 1, values
//    above DEPTH act as DEPTH). Any write empties the deque; write only when idle.
//  - A result goes via the synchronous store read, then the output register.
//  - Throughput: one item per cycle unless stalled (below). Pointers and count update
//    at accept, so the next item sees them at once; the single store port does at
//    most one access per item.
//  - Stall: if the receiver holds rsp_ch.ready low, the output register holds,
//    the read stage fills, and then req_ch.ready drops until the output drains.
//  - Reset: pointers and count clear, capacity returns to 1024 entries; the
//    store contents are not cleared and no clearing pass is needed.
`default_nettype none

module circular_deque_core import cdq_pkg::*; #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   cdq_req_if.sink          req_ch,
   cdq_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);

   localparam int unsigned IDX_W = $clog2(DEPTH);

   logic                   req_accept;
   logic                   s1_advance;
   cdq_mem_ctl_type        mem_ctl;
   logic [IDX_W-1:0]       mem_addr;
   logic [DATA_W-1:0]      mem_rd_data;
   cdq_result_type         op_result;

   // read stage: the item whose store read is in flight
   logic                   s1_valid_ff;
   cdq_result_type         s1_info_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [DATA_W-1:0]      rsp_value_ff;
   cdq_status_type         rsp_status_ff;
   logic [CNT_W-1:0]       rsp_occ_ff;

   // advance the read stage when the output register is free or being taken
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_accept   = req_ch.valid && req_ch.ready;

   cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (req_accept),
      .kind      (req_ch.kind),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .result    (op_result)
   );

   cdq_ring_mem #(.DEPTH(DEPTH)) u_ring (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (req_ch.value),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end else begin
            s1_valid_ff <= s1_valid_ff;
         end
         priority if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= rsp_valid_ff;
         end
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_info_ff <= op_result;
      end
      if (s1_advance) begin
         // drop the store data unless the pop succeeded
         rsp_value_ff  <= s1_info_ff.pop_ok ? mem_rd_data : '0;
         rsp_status_ff <= s1_info_ff.status;
         rsp_occ_ff    <= s1_info_ff.occupancy;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.popped_value = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.occupancy    = rsp_occ_ff;

   // an empty pop leaves nothing behind
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_info_ff.status == STATUS_EMPTY |-> s1_info_ff.occupancy == '0)
      else $error("empty pop reported with nonzero occupancy");

   // a full push can only happen with values held
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_info_ff.status == STATUS_FULL |-> s1_info_ff.occupancy != '0)
      else $error("full push reported with zero occupancy");

   // only a successful pop carries store data out
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_DONE |-> rsp_value_ff == '0)
      else $error("rejected operation returned a nonzero value");

endmodule

`default_nettype wire

FILE: hdl/cdq_ring_mem.sv
// cdq_ring_mem: single-port ring store with a registered read.
// Depends on cdq_pkg for the data width.
`default_nettype none

module cdq_ring_mem import cdq_pkg::*; #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                       clock,
   input  cdq_mem_ctl_type            ctl,
   input  logic [$clog2(DEPTH)-1:0]   addr,
   input  logic [DATA_W-1:0]          wr_data,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] store [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store[addr] <= wr_data;
      end
      // hold the last read so a stalled item keeps its data
      if (ctl.rd_en) begin
         rd_data_ff <= store[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/cdq_ctrl.sv
// cdq_ctrl: head/tail pointers, fill count and capacity register of the deque;
// decides each item's store access and status. Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl import cdq_pkg::*; #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CNT_W-1:0]           csr_wdata,
   input  logic                       accept,
   input  cdq_kind_type               kind,
   output cdq_mem_ctl_type            mem_ctl,
   output logic [$clog2(DEPTH)-1:0]   mem_addr,
   output cdq_result_type             result
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

   logic [CNT_W-1:0] usable_ff, usable_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [CNT_W-1:0] cap;
   logic [IDX_W-1:0] cap_last;
   logic [IDX_W-1:0] head_dec, head_inc, tail_dec, tail_inc;
   logic             full, empty;

   // clamp capacity to 1..DEPTH
   always_comb begin
      priority if (usable_ff == '0) begin
         cap = CNT_W'(1);
      end else if (32'(usable_ff) > DEPTH) begin
         cap = CNT_W'(DEPTH);
      end else begin
         cap = usable_ff;
      end
   end

   assign cap_last = IDX_W'(cap - 1'b1);
   assign head_dec = (head_ff == '0) ? cap_last : head_ff - 1'b1;
   assign tail_dec = (tail_ff == '0) ? cap_last : tail_ff - 1'b1;
   assign head_inc = (CMP_W'(head_ff) + 1'b1 >= CMP_W'(cap)) ? '0 : head_ff + 1'b1;
   assign tail_inc = (CMP_W'(tail_ff) + 1'b1 >= CMP_W'(cap)) ? '0 : tail_ff + 1'b1;
   assign full     = (count_ff >= cap);
   assign empty    = (count_ff == '0);

   always_comb begin
      usable_in        = usable_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      count_in         = count_ff;
      mem_ctl          = '0;
      mem_addr         = head_ff;
      result.pop_ok    = 1'b0;
      result.status    = STATUS_DONE;

      priority if (csr_we) begin
         usable_in = csr_wdata;
         head_in   = '0;
         tail_in   = '0;
         count_in  = '0;
      end else if (accept) begin
         unique case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
               if (full) begin
                  result.status = STATUS_FULL;
               end else begin
                  mem_ctl.wr_en = 1'b1;
                  count_in      = count_ff + 1'b1;
                  priority if (empty) begin
                     // first value: front push lands on the last entry
                     head_in  = (kind == KIND_PUSH_FRONT) ? cap_last : '0;
                     tail_in  = (kind == KIND_PUSH_FRONT) ? cap_last : '0;
                     mem_addr = (kind == KIND_PUSH_FRONT) ? cap_last : '0;
                  end else if (kind == KIND_PUSH_FRONT) begin
                     head_in  = head_dec;
                     mem_addr = head_dec;
                  end else begin
                     tail_in  = tail_inc;
                     mem_addr = tail_inc;
                  end
               end
            end
            KIND_POP_FRONT, KIND_POP_REAR: begin
               if (empty) begin
                  result.status = STATUS_EMPTY;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  result.pop_ok = 1'b1;
                  count_in      = count_ff - 1'b1;
                  if (kind == KIND_POP_FRONT) begin
                     mem_addr = head_ff;
                     head_in  = head_inc;
                  end else begin
                     mem_addr = tail_ff;
                     tail_in  = tail_dec;
                  end
                  // last value gone: park both pointers at entry zero
                  if (count_ff == CNT_W'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end else begin
         // no item and no write: hold pointers, count and capacity
      end
      result.occupancy = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff <= USABLE_RESET;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
      end else begin
         usable_ff <= usable_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: bench/circular_deque_core_tb.sv
`timescale 1ns / 100ps
// circular_deque_core_tb: self-checking bench for the ring-buffer deque core.
// Depends on cdq_pkg, cdq_req_if/cdq_rsp_if and circular_deque_core (hdl folder).

module circular_deque_core_tb;
   import cdq_pkg::*;

   localparam int unsigned RING_DEPTH = 1024;

   // One awaited result item of the deque.
   typedef struct {
      logic signed [DATA_W-1:0] popped_value;
      cdq_status_type           status;
      logic [CNT_W-1:0]         occupancy;
   } deque_result_type;

   // Deque scoreboard: keeps its own ring, pointers and capacity, works out
   // the result of every accepted operation item and matches returned items
   // against those results in order.
   class deque_scoreboard;
      logic [DATA_W-1:0] slots [RING_DEPTH];
      int unsigned       front_pos;
      int unsigned       back_pos;
      int unsigned       fill_level;
      int unsigned       span;
      int unsigned       mismatches;
      deque_result_type  awaited_results[$];

      function new();
         front_pos  = 0;
         back_pos   = 0;
         fill_level = 0;
         span       = USABLE_RESET;
         mismatches = 0;
      endfunction

      // Clamp the written entry count and empty the deque; the ring keeps its data.
      function void set_capacity(logic [CNT_W-1:0] entries);
         if (entries == 0) begin
            span = 1;
         end else if (entries > RING_DEPTH) begin
            span = RING_DEPTH;
         end else begin
            span = entries;
         end
         front_pos  = 0;
         back_pos   = 0;
         fill_level = 0;
      endfunction

      function void note_operation(cdq_kind_type kind, logic signed [DATA_W-1:0] value);
         deque_result_type r;
         r.popped_value = '0;
         r.status       = STATUS_DONE;
         case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
               if (fill_level >= span) begin
                  r.status = STATUS_FULL;
               end else begin
                  if (fill_level == 0) begin
                     // first value: front push lands at the top entry, rear at entry 0
                     front_pos = (kind == KIND_PUSH_FRONT) ? span - 1 : 0;
                     back_pos  = front_pos;
                     slots[front_pos] = value;
                  end else if (kind == KIND_PUSH_FRONT) begin
                     front_pos = (front_pos == 0) ? span - 1 : front_pos - 1;
                     slots[front_pos] = value;
                  end else begin
                     back_pos = (back_pos + 1 >= span) ? 0 : back_pos + 1;
                     slots[back_pos] = value;
                  end
                  fill_level++;
               end
            end
            default: begin
               if (fill_level == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  if (kind == KIND_POP_FRONT) begin
                     r.popped_value = slots[front_pos];
                     front_pos = (front_pos + 1 >= span) ? 0 : front_pos + 1;
                  end else begin
                     r.popped_value = slots[back_pos];
                     back_pos = (back_pos == 0) ? span - 1 : back_pos - 1;
                  end
                  fill_level--;
                  if (fill_level == 0) begin
                     front_pos = 0;
                     back_pos  = 0;
                  end
               end
            end
         endcase
         r.occupancy = CNT_W'(fill_level);
         awaited_results.push_back(r);
      endfunction

      function void check_result(logic signed [DATA_W-1:0] popped_value,
                                 logic [1:0] status, logic [CNT_W-1:0] occupancy);
         deque_result_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            $display("%0t: extra result: expected none, got %0d/%0d/%0d",
                     $time, popped_value, status, occupancy);
            return;
         end
         want = awaited_results.pop_front();
         if (popped_value !== want.popped_value) begin
            mismatches++;
            $display("%0t: popped value mismatch: expected %0d, got %0d",
                     $time, want.popped_value, popped_value);
         end
         if (status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, status);
         end
         if (occupancy !== want.occupancy) begin
            mismatches++;
            $display("%0t: occupancy mismatch: expected %0d, got %0d",
                     $time, want.occupancy, occupancy);
         end
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CNT_W-1:0] csr_wdata;

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();

   deque_scoreboard sb = new();

   // Idle rates: first the sender idles rarely and the receiver often, then the
   // other way round, then neither idles (switched by item count in offer_op).
   int          sender_idle_pct   = 23;
   int          receiver_idle_pct = 76;
   int unsigned ops_offered       = 0;
   int unsigned results_seen      = 0;
   int unsigned hold_left         = 0;

   // Random phases: capacity written, item count and share of pushes.
   // 0 and 2047 exercise the clamping; the 2047 phase builds a deep deque.
   int cap_plan  [8] = '{1, 0, 3, 2047, 2, 7, 16, 100};
   int count_plan[8] = '{40, 40, 50, 640, 50, 60, 60, 60};
   int push_plan [8] = '{60, 60, 55, 97, 55, 55, 55, 50};

   circular_deque_core #(
      .DEPTH(RING_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one operation item, with a random gap first; return at its accept edge.
   task automatic offer_op(cdq_kind_type kind, logic signed [DATA_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_operation(kind, value);
      ops_offered++;
      // advance the idle pattern by thirds of the run
      if (ops_offered == 340) begin
         sender_idle_pct   = 76;
         receiver_idle_pct = 23;
      end else if (ops_offered == 680) begin
         sender_idle_pct   = 0;
         receiver_idle_pct = 0;
      end
   endtask

   // Drop valid and hold until every awaited result has come back.
   task automatic wait_all_returned();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Write the entry count only with the core idle; the write empties the deque.
   task automatic write_capacity(logic [CNT_W-1:0] entries);
      wait_all_returned();
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= entries;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_capacity(entries);
   endtask

   // Mostly plain random data, with the extremes mixed in now and then.
   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(9) != 0) return $urandom;
      case ($urandom_range(3))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         default: return -1;
      endcase
   endfunction

   task automatic run_batch(int count, int push_pct);
      cdq_kind_type kind;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < push_pct) begin
            kind = $urandom_range(1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
         end else begin
            kind = $urandom_range(1) ? KIND_POP_REAR : KIND_POP_FRONT;
         end
         offer_op(kind, pick_value());
      end
   endtask

   // Stimulus: directed items, then random phases at several capacities.
   initial begin
      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_PUSH_FRONT;
      req_ch.value <= '0;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      reset        <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset capacity: pops on empty, pushes of the data extremes at both ends,
      // pops from both ends to empty, one more empty pop, then a rear push and its pop.
      offer_op(KIND_POP_FRONT, 32'sd17);
      offer_op(KIND_POP_REAR, -32'sd17);
      offer_op(KIND_PUSH_FRONT, 32'sh7FFF_FFFF);
      offer_op(KIND_PUSH_REAR, 32'sh8000_0000);
      offer_op(KIND_PUSH_FRONT, '0);
      offer_op(KIND_PUSH_REAR, -1);
      offer_op(KIND_POP_REAR, '0);
      offer_op(KIND_POP_FRONT, -1);
      offer_op(KIND_POP_FRONT, '0);
      offer_op(KIND_POP_REAR, '0);
      offer_op(KIND_POP_FRONT, '0);
      offer_op(KIND_PUSH_REAR, 32'sd5);
      offer_op(KIND_POP_FRONT, '0);

      // One-entry ring: pushes on full from both ends, wrap of a single slot.
      write_capacity(11'd1);
      offer_op(KIND_PUSH_REAR, 32'sh1234_5678);
      offer_op(KIND_PUSH_REAR, 32'sd9);
      offer_op(KIND_PUSH_FRONT, 32'sd10);
      offer_op(KIND_POP_FRONT, '0);
      offer_op(KIND_PUSH_FRONT, 32'shCAFE_F00D);
      offer_op(KIND_POP_REAR, '0);

      // Random phases; a write can land with values still held, so the
      // emptying on a capacity change is exercised too.
      for (int p = 0; p < 8; p++) begin
         write_capacity(CNT_W'(cap_plan[p]));
         run_batch(count_plan[p], push_plan[p]);
      end

      wait_all_returned();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("circular_deque_core regression: pass");
      end else begin
         $display("circular_deque_core regression: fail");
      end
      $finish;
   end

   // Receiver: check each returned item, stall at random, and once hold off
   // long enough that the core fills its pipeline and stalls its input.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.popped_value, rsp_ch.status, rsp_ch.occupancy);
            results_seen++;
            if (results_seen == 120) hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Run limit, several times the slowest correct run.
   initial begin
      #2_000_000;
      $display("circular_deque_core regression: fail");
      $finish;
   end

endmodule
